@@ design/flvp_pkg.sv @@
// Package: shared types, constants and codes for the FLV tag packetizer.
`timescale 1ns / 1ps
`default_nettype none
package flvp_pkg;

	// Command queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// Burst byte index (longest burst is 25 bytes)
	localparam int BIDX_W = 5;
	localparam logic [BIDX_W-1:0] LAST_PASS      = 5'd0;
	localparam logic [BIDX_W-1:0] LAST_AUDIO     = 5'd16;
	localparam logic [BIDX_W-1:0] LAST_AUDIO_AAC = 5'd17;
	localparam logic [BIDX_W-1:0] LAST_VIDEO     = 5'd24;

	// Configuration port
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam logic [2:0] REG_FRAME_STEP   = 3'd0;
	localparam logic [2:0] REG_SOUND_TYPE   = 3'd1;
	localparam logic [2:0] REG_SOUND_SIZE   = 3'd2;
	localparam logic [2:0] REG_SOUND_RATE   = 3'd3;
	localparam logic [2:0] REG_SOUND_FORMAT = 3'd4;
	localparam logic [9:0] FRAME_STEP_RESET = 10'd40;

	// Tag stream constants
	localparam logic [7:0] TAG_AUDIO   = 8'h08;
	localparam logic [7:0] TAG_VIDEO   = 8'h09;
	localparam logic [7:0] VIDEO_KEY   = 8'h17;
	localparam logic [7:0] VIDEO_INTER = 8'h27;
	localparam logic [7:0] AVC_NALU    = 8'h01;
	localparam logic [3:0] NAL_IDR     = 4'd5;
	localparam logic [3:0] FMT_AAC     = 4'd10;
	localparam logic [7:0] START_ONE   = 8'h01;
	localparam logic [2:0] POS_SC_TYPE = 3'd2;
	localparam logic [2:0] POS_NAL_SH  = 3'd3;
	localparam logic [2:0] POS_NAL_LG  = 3'd4;
	localparam logic [2:0] POS_MAX     = 3'd7;

	typedef enum logic [2:0] {
		CMD_PASS  = 3'b001,
		CMD_VIDEO = 3'b010,
		CMD_AUDIO = 3'b100
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data_byte;
		logic        eof;
		logic [31:0] prev_size;
		logic [23:0] data_size;
		logic [31:0] tstamp;
		logic [31:0] nal_len;
		logic        key;
		logic [7:0]  snd_hdr;
		logic        aac;
		logic        aac_seq;
	} cmd_t;

	typedef struct packed {
		logic [9:0] frame_step_ms;
		logic       sound_type;
		logic       sound_size;
		logic [1:0] sound_rate;
		logic [3:0] sound_format;
	} cfg_t;

	typedef struct packed {
		logic             full;
		logic             empty;
		logic [CNT_W-1:0] count;
	} fifo_stat_t;

endpackage
`default_nettype wire

@@ design/flvp_in_if.sv @@
// Interface: input byte channel of the FLV tag packetizer.
`timescale 1ns / 1ps
`default_nettype none
interface flvp_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [7:0]  data_byte;
	logic        start_of_frame;
	logic        end_of_frame;
	logic [23:0] frame_length;

	modport source (
		output valid, func, data_byte, start_of_frame, end_of_frame, frame_length,
		input  ready
	);
	modport sink (
		input  valid, func, data_byte, start_of_frame, end_of_frame, frame_length,
		output ready
	);
endinterface
`default_nettype wire

@@ design/flvp_out_if.sv @@
// Interface: output tag byte channel of the FLV tag packetizer.
`timescale 1ns / 1ps
`default_nettype none
interface flvp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       end_of_tag;

	modport source (
		output valid, out_byte, last_of_run, end_of_tag,
		input  ready
	);
	modport sink (
		input  valid, out_byte, last_of_run, end_of_tag,
		output ready
	);
endinterface
`default_nettype wire

@@ design/flvp_front.sv @@
// Front end: accepts input beats, tracks frame state and issues tag commands.
`timescale 1ns / 1ps
`default_nettype none
module flvp_front (
	input  wire                     clk,
	input  wire                     arst_n,
	input  flvp_pkg::cfg_t          cfg,
	flvp_in_if.sink                 in_ch,
	input  flvp_pkg::fifo_stat_t    fifo_st,
	output logic                    push,
	output flvp_pkg::cmd_t          cmd
);
	import flvp_pkg::*;

	logic [31:0] prev_size_q;
	logic [31:0] tstamp_q;
	logic        aac_sent_q;
	logic [2:0]  pos_q;
	logic        short_q;
	logic [23:0] held_len_q;
	logic        hdr_done_q;

	logic        accept;
	logic [2:0]  pos_eff;
	logic        hd_eff;
	logic [23:0] len_eff;
	logic        is_aac;
	logic [23:0] aud_size;
	logic [31:0] skip;
	logic [31:0] nal_len;
	logic [23:0] vid_size;
	logic        nal;

	// Accept while the command queue has room
	assign in_ch.ready = !fifo_st.full;
	assign accept      = in_ch.valid && in_ch.ready;

	// Start of frame restarts position and header tracking
	assign pos_eff  = in_ch.start_of_frame ? 3'd0 : pos_q;
	assign hd_eff   = in_ch.start_of_frame ? 1'b0 : hdr_done_q;
	assign len_eff  = in_ch.start_of_frame ? in_ch.frame_length : held_len_q;

	// Tag sizes
	assign is_aac   = (cfg.sound_format == FMT_AAC);
	assign aud_size = len_eff + 24'd1 + {23'd0, is_aac};
	assign skip     = short_q ? 32'd3 : 32'd4;
	assign nal_len  = {8'd0, len_eff} - skip;
	assign vid_size = nal_len[23:0] + 24'd9;

	// NAL header byte sits right after the start code
	assign nal = !in_ch.func && !hd_eff &&
		(((pos_eff == POS_NAL_SH) && short_q) || ((pos_eff == POS_NAL_LG) && !short_q));

	// Build the command for this beat
	always_comb begin
		cmd.kind      = CMD_PASS;
		cmd.data_byte = in_ch.data_byte;
		cmd.eof       = in_ch.end_of_frame;
		cmd.prev_size = prev_size_q;
		cmd.data_size = in_ch.func ? aud_size : vid_size;
		cmd.tstamp    = tstamp_q;
		cmd.nal_len   = nal_len;
		cmd.key       = (in_ch.data_byte[3:0] == NAL_IDR);
		cmd.snd_hdr   = {cfg.sound_format, cfg.sound_rate, cfg.sound_size, cfg.sound_type};
		cmd.aac       = is_aac;
		cmd.aac_seq   = aac_sent_q;
		if (in_ch.func && in_ch.start_of_frame) begin
			cmd.kind = CMD_AUDIO;
		end else if (nal) begin
			cmd.kind = CMD_VIDEO;
		end
	end

	// Start code bytes of video produce no command
	assign push = accept && (in_ch.func || hd_eff || nal);

	// Advance frame state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_size_q <= '0;
			tstamp_q    <= '0;
			aac_sent_q  <= 1'b0;
			pos_q       <= '0;
			short_q     <= 1'b0;
			held_len_q  <= '0;
			hdr_done_q  <= 1'b0;
		end else if (accept) begin
			held_len_q <= len_eff;
			pos_q      <= pos_eff;
			hdr_done_q <= hd_eff;
			if (in_ch.func) begin
				if (in_ch.start_of_frame) begin
					prev_size_q <= {8'd0, aud_size} + 32'd11;
					hdr_done_q  <= 1'b1;
					if (is_aac) begin
						aac_sent_q <= 1'b1;
					end
				end
			end else if (!hd_eff) begin
				if (pos_eff == POS_SC_TYPE) begin
					short_q <= (in_ch.data_byte == START_ONE);
				end
				if (pos_eff < POS_MAX) begin
					pos_q <= pos_eff + 3'd1;
				end
				if (nal) begin
					prev_size_q <= {8'd0, vid_size} + 32'd11;
					tstamp_q    <= tstamp_q + {22'd0, cfg.frame_step_ms};
					hdr_done_q  <= 1'b1;
				end
			end
			if (in_ch.end_of_frame) begin
				pos_q      <= '0;
				hdr_done_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ design/flvp_fifo.sv @@
// Command queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module flvp_fifo (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	input  flvp_pkg::cmd_t          wr_data,
	input  wire                     pop,
	output flvp_pkg::cmd_t          rd_data,
	output flvp_pkg::fifo_stat_t    st
);
	import flvp_pkg::*;

	cmd_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign st.count = count_q;
	assign st.full  = (count_q == CNT_W'(FIFO_DEPTH));
	assign st.empty = (count_q == '0);
	assign rd_data  = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Move pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ design/flvp_back.sv @@
// Back end: expands each command into tag stream bytes behind an output register.
`timescale 1ns / 1ps
`default_nettype none
module flvp_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     empty,
	input  flvp_pkg::cmd_t          cmd,
	output logic                    pop,
	flvp_out_if.source              out_ch
);
	import flvp_pkg::*;

	logic [BIDX_W-1:0] idx_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	logic              out_eot_q;

	logic              load;
	logic              emit;
	logic              at_last;
	logic [BIDX_W-1:0] last_idx;
	logic [7:0]        hdr_byte;
	logic [7:0]        cur_byte;

	// Last byte index of this command's burst
	always_comb begin
		case (cmd.kind)
			CMD_VIDEO: last_idx = LAST_VIDEO;
			CMD_AUDIO: last_idx = cmd.aac ? LAST_AUDIO_AAC : LAST_AUDIO;
			CMD_PASS:  last_idx = LAST_PASS;
			default:   last_idx = LAST_PASS;
		endcase
	end

	// Previous tag size and 11-byte tag header
	always_comb begin
		case (idx_q)
			5'd0:    hdr_byte = cmd.prev_size[31:24];
			5'd1:    hdr_byte = cmd.prev_size[23:16];
			5'd2:    hdr_byte = cmd.prev_size[15:8];
			5'd3:    hdr_byte = cmd.prev_size[7:0];
			5'd4:    hdr_byte = (cmd.kind == CMD_VIDEO) ? TAG_VIDEO : TAG_AUDIO;
			5'd5:    hdr_byte = cmd.data_size[23:16];
			5'd6:    hdr_byte = cmd.data_size[15:8];
			5'd7:    hdr_byte = cmd.data_size[7:0];
			5'd8:    hdr_byte = cmd.tstamp[23:16];
			5'd9:    hdr_byte = cmd.tstamp[15:8];
			5'd10:   hdr_byte = cmd.tstamp[7:0];
			5'd11:   hdr_byte = cmd.tstamp[31:24];
			default: hdr_byte = 8'h00;
		endcase
	end

	// Pick the byte for the current burst position
	always_comb begin
		cur_byte = cmd.data_byte;
		case (cmd.kind)
			CMD_VIDEO: begin
				case (idx_q)
					5'd15:   cur_byte = cmd.key ? VIDEO_KEY : VIDEO_INTER;
					5'd16:   cur_byte = AVC_NALU;
					5'd17,
					5'd18,
					5'd19:   cur_byte = 8'h00;
					5'd20:   cur_byte = cmd.nal_len[31:24];
					5'd21:   cur_byte = cmd.nal_len[23:16];
					5'd22:   cur_byte = cmd.nal_len[15:8];
					5'd23:   cur_byte = cmd.nal_len[7:0];
					5'd24:   cur_byte = cmd.data_byte;
					default: cur_byte = hdr_byte;
				endcase
			end
			CMD_AUDIO: begin
				case (idx_q)
					5'd15:   cur_byte = cmd.snd_hdr;
					5'd16:   cur_byte = cmd.aac ? {7'd0, cmd.aac_seq} : cmd.data_byte;
					5'd17:   cur_byte = cmd.data_byte;
					default: cur_byte = hdr_byte;
				endcase
			end
			CMD_PASS: cur_byte = cmd.data_byte;
			default:  cur_byte = cmd.data_byte;
		endcase
	end

	assign load    = !out_valid_q || out_ch.ready;
	assign emit    = load && !empty;
	assign at_last = (idx_q == last_idx);
	assign pop     = emit && at_last;

	// Walk the burst and release the command after its last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !empty;
			if (!empty) begin
				idx_q <= at_last ? '0 : idx_q + BIDX_W'(1);
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= cur_byte;
			out_last_q <= at_last;
			out_eot_q  <= at_last && cmd.eof;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_byte    = out_byte_q;
	assign out_ch.last_of_run = out_last_q;
	assign out_ch.end_of_tag  = out_eot_q;

endmodule
`default_nettype wire

@@ design/flv_av_tag_packetizer_top.sv @@
// Top level: FLV tag packetizer with configuration registers.
`timescale 1ns / 1ps
`default_nettype none
// Wraps H.264 Annex-B video bytes and audio bytes into an FLV tag stream, one
// output byte per cycle while the receiver is ready. Payload bytes pass through
// as one output byte each, so a steady stream then sustains one input beat per
// cycle. The NAL header byte of a video frame expands into a 25-byte burst and
// the first byte of an audio frame into 17 bytes (18 for AAC); such a beat
// occupies the output for its burst, and the input stalls once the 4-entry
// command queue between the front and back ends is full. Start code bytes of a
// video frame produce no output. Configuration is written through the APB port
// by the user only while the block is idle; the block does not enforce this.
module flv_av_tag_packetizer_top (
	input  wire                              clk,
	input  wire                              arst_n,
	flvp_in_if.sink                          in_ch,
	flvp_out_if.source                       out_ch,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [flvp_pkg::PADDR_W-1:0]     paddr,
	input  wire  [flvp_pkg::PDATA_W-1:0]     pwdata,
	output logic [flvp_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);
	import flvp_pkg::*;

	cfg_t       cfg_q;
	logic       cfg_wr;
	logic [2:0] reg_idx;
	logic       push;
	logic       pop;
	cmd_t       push_cmd;
	cmd_t       pop_cmd;
	fifo_stat_t fifo_st;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_step_ms <= FRAME_STEP_RESET;
			cfg_q.sound_type    <= 1'b0;
			cfg_q.sound_size    <= 1'b0;
			cfg_q.sound_rate    <= 2'd0;
			cfg_q.sound_format  <= 4'd0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_FRAME_STEP:   cfg_q.frame_step_ms <= pwdata[9:0];
				REG_SOUND_TYPE:   cfg_q.sound_type    <= pwdata[0];
				REG_SOUND_SIZE:   cfg_q.sound_size    <= pwdata[0];
				REG_SOUND_RATE:   cfg_q.sound_rate    <= pwdata[1:0];
				REG_SOUND_FORMAT: cfg_q.sound_format  <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (reg_idx)
			REG_FRAME_STEP:   prdata = {22'd0, cfg_q.frame_step_ms};
			REG_SOUND_TYPE:   prdata = {31'd0, cfg_q.sound_type};
			REG_SOUND_SIZE:   prdata = {31'd0, cfg_q.sound_size};
			REG_SOUND_RATE:   prdata = {30'd0, cfg_q.sound_rate};
			REG_SOUND_FORMAT: prdata = {28'd0, cfg_q.sound_format};
			default:          prdata = '0;
		endcase
	end

	flvp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_ch   (in_ch),
		.fifo_st (fifo_st),
		.push    (push),
		.cmd     (push_cmd)
	);

	flvp_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_cmd),
		.pop     (pop),
		.rd_data (pop_cmd),
		.st      (fifo_st)
	);

	flvp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (fifo_st.empty),
		.cmd    (pop_cmd),
		.pop    (pop),
		.out_ch (out_ch)
	);

`ifndef SYNTHESIS
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_st.count <= CNT_W'(FIFO_DEPTH))
		else $error("command queue count exceeds depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_st.empty)
		else $error("command popped from empty queue");

	a_eot_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.end_of_tag) |-> out_ch.last_of_run)
		else $error("end of tag on a beat that does not close its run");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !fifo_st.full)
		else $error("command pushed into full queue");
`endif

endmodule
`default_nettype wire

@@ test/tb_flv_av_tag_packetizer_top.sv @@
// Testbench: FLV tag packetizer, directed table and random frames checked byte by byte.
`timescale 1ns / 1ps
module tb_flv_av_tag_packetizer_top;
	import flvp_pkg::*;

	localparam logic FUNC_VIDEO = 1'b0;
	localparam logic FUNC_AUDIO = 1'b1;
	localparam int   FROM_PREDICTOR = -1;
	localparam int   CYCLE_LIMIT = 400000;
	localparam int   HOLD_CYCLES = 300;
	localparam int   IDLE_SETTLE = 40;
	localparam int   PHASE_BEATS = 50;
	localparam int   PRINT_CAP = 40;

	typedef struct packed {
		logic        func;
		logic [7:0]  data_byte;
		logic        sof;
		logic        eof;
		logic [23:0] flen;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       eot;
	} tag_byte_t;

	typedef struct {
		in_beat_t beat;
		int       typed_n;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic        pready;

	flvp_in_if  in_ch ();
	flvp_out_if out_ch ();

	flv_av_tag_packetizer_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow registers and tag state of the predictor
	cfg_t        cfg;
	logic [31:0] prev_tag_size;
	logic [31:0] tstamp_ms;
	logic        aac_seq_sent;
	logic [2:0]  sc_pos;
	logic        short_sc;
	logic [23:0] held_len;
	logic        hdr_done;

	tag_byte_t tag_run_q[$];
	tag_byte_t tag_bytes_due[$];
	dir_row_t  dir_rows[$];

	int err_cnt = 0;
	int beats_sent = 0;
	int tag_bytes_seen = 0;
	int cycle_cnt = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int row_typed_n = FROM_PREDICTOR;
	bit hold_req = 1'b0;
	int hold_left = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		if (err_cnt < PRINT_CAP)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		err_cnt++;
	endtask

	function automatic void put_tag_byte(logic [7:0] b);
		tag_run_q.push_back('{b, 1'b0, 1'b0});
	endfunction

	// Emit previous tag size and the 11-byte tag header, then latch the new size
	function automatic void put_tag_header(logic [7:0] kind, logic [23:0] dsize);
		for (int i = 3; i >= 0; i--)
			put_tag_byte(prev_tag_size[8*i +: 8]);
		put_tag_byte(kind);
		for (int i = 2; i >= 0; i--)
			put_tag_byte(dsize[8*i +: 8]);
		for (int i = 2; i >= 0; i--)
			put_tag_byte(tstamp_ms[8*i +: 8]);
		put_tag_byte(tstamp_ms[31:24]);
		repeat (3) put_tag_byte(8'h00);
		prev_tag_size = 32'(dsize) + 32'd11;
	endfunction

	// Compute the tag bytes one accepted input beat produces
	function automatic void predict_tag_bytes(in_beat_t ib);
		logic        is_aac;
		logic        nal;
		logic [31:0] nal_len;
		tag_run_q.delete();
		if (ib.sof) begin
			sc_pos = '0;
			hdr_done = 1'b0;
			held_len = ib.flen;
		end
		if (ib.func == FUNC_AUDIO) begin
			if (ib.sof) begin
				is_aac = (cfg.sound_format == FMT_AAC);
				put_tag_header(TAG_AUDIO, held_len + 24'd1 + {23'd0, is_aac});
				put_tag_byte({cfg.sound_format, cfg.sound_rate, cfg.sound_size, cfg.sound_type});
				if (is_aac) begin
					put_tag_byte(aac_seq_sent ? 8'h01 : 8'h00);
					aac_seq_sent = 1'b1;
				end
				hdr_done = 1'b1;
			end
			put_tag_byte(ib.data_byte);
		end else if (hdr_done) begin
			put_tag_byte(ib.data_byte);
		end else begin
			// Walk the start code; the NAL header byte follows it
			nal = 1'b0;
			if (sc_pos == POS_SC_TYPE)
				short_sc = (ib.data_byte == START_ONE);
			else if (sc_pos == POS_NAL_SH && short_sc)
				nal = 1'b1;
			else if (sc_pos == POS_NAL_LG && !short_sc)
				nal = 1'b1;
			if (sc_pos < POS_MAX)
				sc_pos++;
			if (nal) begin
				nal_len = 32'(held_len) - (short_sc ? 32'd3 : 32'd4);
				put_tag_header(TAG_VIDEO, nal_len[23:0] + 24'd9);
				put_tag_byte((ib.data_byte[3:0] == NAL_IDR) ? VIDEO_KEY : VIDEO_INTER);
				put_tag_byte(AVC_NALU);
				repeat (3) put_tag_byte(8'h00);
				for (int i = 3; i >= 0; i--)
					put_tag_byte(nal_len[8*i +: 8]);
				put_tag_byte(ib.data_byte);
				tstamp_ms = tstamp_ms + 32'(cfg.frame_step_ms);
				hdr_done = 1'b1;
			end
		end
		if (tag_run_q.size() > 0) begin
			tag_run_q[tag_run_q.size()-1].last = 1'b1;
			tag_run_q[tag_run_q.size()-1].eot = ib.eof;
		end
		if (ib.eof) begin
			sc_pos = '0;
			hdr_done = 1'b0;
		end
	endfunction

	// Predict on input beats, check output beats; input first so a fast result finds its entry
	always @(posedge clk) begin
		in_beat_t  ib;
		tag_byte_t want;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			ib = '{in_ch.func, in_ch.data_byte, in_ch.start_of_frame,
				in_ch.end_of_frame, in_ch.frame_length};
			predict_tag_bytes(ib);
			if (row_typed_n != FROM_PREDICTOR) begin
				tag_run_q.delete();
				if (row_typed_n == 1)
					tag_run_q.push_back('{ib.data_byte, 1'b1, ib.eof});
			end
			foreach (tag_run_q[i])
				tag_bytes_due.push_back(tag_run_q[i]);
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (tag_bytes_due.size() == 0) begin
				report_mismatch($sformatf("tag byte %0d: unexpected byte %02h",
					tag_bytes_seen, out_ch.out_byte));
			end else begin
				want = tag_bytes_due.pop_front();
				if (out_ch.out_byte !== want.data)
					report_mismatch($sformatf("tag byte %0d: out_byte %02h, want %02h",
						tag_bytes_seen, out_ch.out_byte, want.data));
				if (out_ch.last_of_run !== want.last)
					report_mismatch($sformatf("tag byte %0d: last_of_run %b, want %b",
						tag_bytes_seen, out_ch.last_of_run, want.last));
				if (out_ch.end_of_tag !== want.eot)
					report_mismatch($sformatf("tag byte %0d: end_of_tag %b, want %b",
						tag_bytes_seen, out_ch.end_of_tag, want.eot));
			end
			tag_bytes_seen++;
		end
	end

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Offer one beat, idling first at random; hold valid until accepted
	task automatic send_beat(logic func, logic [7:0] b, logic sof, logic eof,
			logic [23:0] flen, int typed_n);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.func           <= func;
		in_ch.data_byte      <= b;
		in_ch.start_of_frame <= sof;
		in_ch.end_of_frame   <= eof;
		in_ch.frame_length   <= flen;
		row_typed_n = typed_n;
		do @(posedge clk); while (!in_ch.ready);
		beats_sent++;
	endtask

	// Drop valid and wait until every tag byte is out and the front end is quiet
	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (tag_bytes_due.size() != 0)
			@(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	// Write one register, then read it back while the address still points at it
	task automatic write_reg(logic [2:0] idx, logic [PDATA_W-1:0] val);
		logic [PDATA_W-1:0] rd_mask;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		rd_mask = '0;
		case (idx)
			REG_FRAME_STEP: begin
				cfg.frame_step_ms = val[9:0];
				rd_mask = 32'h0000_03ff;
			end
			REG_SOUND_TYPE: begin
				cfg.sound_type = val[0];
				rd_mask = 32'h0000_0001;
			end
			REG_SOUND_SIZE: begin
				cfg.sound_size = val[0];
				rd_mask = 32'h0000_0001;
			end
			REG_SOUND_RATE: begin
				cfg.sound_rate = val[1:0];
				rd_mask = 32'h0000_0003;
			end
			REG_SOUND_FORMAT: begin
				cfg.sound_format = val[3:0];
				rd_mask = 32'h0000_000f;
			end
			default: ;
		endcase
		if (prdata !== (val & rd_mask))
			report_mismatch($sformatf("register %0d: readback %08h, want %08h",
				idx, prdata, val & rd_mask));
	endtask

	function automatic void add_row(logic func, logic [7:0] b, logic sof, logic eof,
			logic [23:0] flen, int typed_n);
		dir_rows.push_back('{'{func, b, sof, eof, flen}, typed_n});
	endfunction

	// Well-formed Annex-B frame with random content; sometimes cut short or without sof
	task automatic send_video_frame();
		bit          drop_sof;
		int          sc_len;
		int          total;
		int          last;
		logic [7:0]  nal_hdr;
		logic [7:0]  b;
		logic [23:0] len;
		sc_len = $urandom_range(1) ? 3 : 4;
		total = sc_len + 1 + $urandom_range(4);
		nal_hdr = 8'($urandom);
		if ($urandom_range(2) == 0)
			nal_hdr[3:0] = NAL_IDR;
		len = ($urandom_range(4) == 0) ? 24'($urandom) : 24'(total);
		drop_sof = ($urandom_range(9) == 0);
		last = ($urandom_range(9) == 0) ? $urandom_range(sc_len - 1) : total - 1;
		for (int i = 0; i <= last; i++) begin
			if (i == sc_len)
				b = nal_hdr;
			else if (i > sc_len)
				b = 8'($urandom);
			else if (i == sc_len - 1)
				b = START_ONE;
			else if (i == 2)
				b = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255, 2));
			else
				b = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00;
			send_beat(FUNC_VIDEO, b, (i == 0) && !drop_sof, i == last, len, FROM_PREDICTOR);
		end
	endtask

	task automatic send_audio_frame();
		int          n;
		logic [23:0] len;
		n = $urandom_range(5, 1);
		len = ($urandom_range(4) == 0) ? 24'($urandom) : 24'(n);
		for (int i = 0; i < n; i++)
			send_beat(FUNC_AUDIO, 8'($urandom), i == 0, i == n - 1, len, FROM_PREDICTOR);
	endtask

	initial begin
		cfg_t next_cfg;
		int   pick;
		int   phase_start;

		// Drive every input known from time zero
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.func = FUNC_VIDEO;
		in_ch.data_byte = '0;
		in_ch.start_of_frame = 1'b0;
		in_ch.end_of_frame = 1'b0;
		in_ch.frame_length = '0;
		cfg = '0;
		cfg.frame_step_ms = FRAME_STEP_RESET;
		prev_tag_size = '0;
		tstamp_ms = '0;
		aac_seq_sent = 1'b0;
		sc_pos = '0;
		short_sc = 1'b0;
		held_len = '0;
		hdr_done = 1'b0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Long start code, IDR frame of seven bytes
		add_row(FUNC_VIDEO, 8'h00, 1, 0, 24'd7, 0);
		add_row(FUNC_VIDEO, 8'h00, 0, 0, 24'd7, 0);
		add_row(FUNC_VIDEO, 8'h00, 0, 0, 24'd7, 0);
		add_row(FUNC_VIDEO, 8'h01, 0, 0, 24'd7, 0);
		add_row(FUNC_VIDEO, 8'h65, 0, 0, 24'd7, FROM_PREDICTOR);
		add_row(FUNC_VIDEO, 8'hAA, 0, 0, 24'd7, 1);
		add_row(FUNC_VIDEO, 8'hBB, 0, 1, 24'd7, 1);
		// Short start code, inter frame, largest length
		add_row(FUNC_VIDEO, 8'h00, 1, 0, 24'hFFFFFF, 0);
		add_row(FUNC_VIDEO, 8'h00, 0, 0, 24'hFFFFFF, 0);
		add_row(FUNC_VIDEO, 8'h01, 0, 0, 24'hFFFFFF, 0);
		add_row(FUNC_VIDEO, 8'h41, 0, 0, 24'hFFFFFF, FROM_PREDICTOR);
		add_row(FUNC_VIDEO, 8'hFF, 0, 1, 24'hFFFFFF, 1);
		// Frame that ends before its NAL header: no output
		add_row(FUNC_VIDEO, 8'h00, 1, 1, 24'd1, 0);
		// Length shorter than the start code: NAL length wraps
		add_row(FUNC_VIDEO, 8'h00, 1, 0, 24'd1, 0);
		add_row(FUNC_VIDEO, 8'h00, 0, 0, 24'd1, 0);
		add_row(FUNC_VIDEO, 8'h00, 0, 0, 24'd1, 0);
		add_row(FUNC_VIDEO, 8'h00, 0, 0, 24'd1, 0);
		add_row(FUNC_VIDEO, 8'h15, 0, 1, 24'd1, FROM_PREDICTOR);
		// Frame without start-of-frame reuses the held length
		add_row(FUNC_VIDEO, 8'h12, 0, 0, 24'd1, 0);
		add_row(FUNC_VIDEO, 8'h34, 0, 0, 24'd1, 0);
		add_row(FUNC_VIDEO, 8'h01, 0, 0, 24'd1, 0);
		add_row(FUNC_VIDEO, 8'h05, 0, 1, 24'd1, FROM_PREDICTOR);
		// Audio frames; the last one wraps the data size to zero
		add_row(FUNC_AUDIO, 8'h7F, 1, 0, 24'd2, FROM_PREDICTOR);
		add_row(FUNC_AUDIO, 8'h80, 0, 1, 24'd2, 1);
		add_row(FUNC_AUDIO, 8'h00, 1, 1, 24'hFFFFFF, FROM_PREDICTOR);

		foreach (dir_rows[i])
			send_beat(dir_rows[i].beat.func, dir_rows[i].beat.data_byte, dir_rows[i].beat.sof,
				dir_rows[i].beat.eof, dir_rows[i].beat.flen, dir_rows[i].typed_n);
		wait_idle();

		// Random phases: new settings and a new idling pattern each
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					next_cfg = '{10'd0, 1'b1, 1'b1, 2'd3, FMT_AAC};
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					next_cfg = '{10'd1000, 1'b0, 1'b0, 2'd0, 4'd15};
					send_idle_pct = 58;
					recv_stall_pct = 0;
				end
				2: begin
					next_cfg = '{10'd1023, 1'b1, 1'b0, 2'd2, FMT_AAC};
					send_idle_pct = 0;
					recv_stall_pct = 58;
				end
				default: begin
					next_cfg = cfg_t'($urandom);
					send_idle_pct = 6;
					recv_stall_pct = 6;
				end
			endcase
			write_reg(REG_FRAME_STEP, 32'(next_cfg.frame_step_ms));
			write_reg(REG_SOUND_TYPE, 32'(next_cfg.sound_type));
			write_reg(REG_SOUND_SIZE, 32'(next_cfg.sound_size));
			write_reg(REG_SOUND_RATE, 32'(next_cfg.sound_rate));
			write_reg(REG_SOUND_FORMAT, 32'(next_cfg.sound_format));

			phase_start = beats_sent;
			// Hold off the receiver while video headers pile up behind it
			if (ph == 0) begin
				hold_req = 1'b1;
				repeat (6) send_video_frame();
			end
			while (beats_sent - phase_start < PHASE_BEATS) begin
				pick = $urandom_range(99);
				if (pick < 45)
					send_video_frame();
				else if (pick < 82)
					send_audio_frame();
				else
					send_beat(1'($urandom), 8'($urandom), $urandom_range(3) == 0,
						$urandom_range(3) == 0, 24'($urandom), FROM_PREDICTOR);
			end
			wait_idle();
		end

		if (err_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
